>>> hdl/ptaw_pkg.sv
// ---------------------------------------------------------------------------
// ptaw_pkg
// Types and constants shared by the incremental PID core, its checker
// and its test bench.
// ---------------------------------------------------------------------------
`default_nettype none

package ptaw_pkg;

    // Widths of the item fields
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ERR_W    = SAMPLE_W + 1;
    localparam int unsigned Q_W      = 32;
    localparam int unsigned PROD_W   = Q_W + ERR_W;
    // out_last plus three products fits in PROD_W + 2 bits
    localparam int unsigned ACC_W    = PROD_W + 3;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_NOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDUP_GUARD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd6;

    // Request commands
    localparam logic CMD_COMPUTE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // Reset values of the limits
    localparam logic signed [Q_W-1:0] OUT_MAX_RST = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] OUT_MIN_RST = 32'sh8000_0000;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] measured;
    } t_in_item;

    typedef struct packed {
        logic signed [Q_W-1:0] control_out;
        logic                  saturated;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [Q_W-1:0]       wdata;
    } t_cfg_req;

endpackage

`default_nettype wire

>>> hdl/ptaw_chan_if.sv
// ---------------------------------------------------------------------------
// ptaw_chan_if
// Valid/ready channel carrying one payload word per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptaw_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    modport mon    (input valid, input data, input ready);
endinterface

`default_nettype wire

>>> hdl/pid_tustin_antiwindup_core.sv
// ---------------------------------------------------------------------------
// pid_tustin_antiwindup_core
// Velocity-form PID step in Q16.16 with output clamp and anti-windup.
// ---------------------------------------------------------------------------
// Path: input register, then result register; held while output stalls.
// Throughput: one request per cycle unless the result stalls; the error
//   history and last output are updated in the same cycle the product sum
//   is taken, so items chain.
// Reset: synchronous, active low; clears valids, history and registers to
//   their defaults (limits wide open, windup guard on, disabled).
`default_nettype none

module pid_tustin_antiwindup_core
    import ptaw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptaw_chan_if.sink   i_in,
    ptaw_chan_if.source o_out,
    ptaw_chan_if.sink   i_cfg
);

    // Configuration registers
    logic signed [Q_W-1:0] r_coef_now, r_coef_prev, r_coef_prev2;
    logic signed [Q_W-1:0] r_out_max, r_out_min;
    logic                  r_windup_guard, r_enable;

    // Controller state
    logic signed [ERR_W-1:0] r_err_last, r_err_before_last;
    logic signed [Q_W-1:0]   r_out_last;

    // Input stage and result register
    logic     r_s1_valid;
    t_in_item r_s1;
    logic      r_out_valid;
    t_out_item r_out;

    logic out_free, s1_adv;

    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W-1:0] prod_now, prod_prev, prod_prev2;
    logic signed [ACC_W-1:0]  raw;
    logic                     above, below, sat, hold_hist;
    t_out_item                n_out;

    // Config port always takes writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_now     <= '0;
            r_coef_prev    <= '0;
            r_coef_prev2   <= '0;
            r_out_max      <= OUT_MAX_RST;
            r_out_min      <= OUT_MIN_RST;
            r_windup_guard <= 1'b1;
            r_enable       <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_COEF_NOW:     r_coef_now     <= i_cfg.data.wdata;
                CFG_COEF_PREV:    r_coef_prev    <= i_cfg.data.wdata;
                CFG_COEF_PREV2:   r_coef_prev2   <= i_cfg.data.wdata;
                CFG_OUT_MAX:      r_out_max      <= i_cfg.data.wdata;
                CFG_OUT_MIN:      r_out_min      <= i_cfg.data.wdata;
                CFG_WINDUP_GUARD: r_windup_guard <= i_cfg.data.wdata[0];
                CFG_ENABLE:       r_enable       <= i_cfg.data.wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_in.ready  = !r_s1_valid || out_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1 <= i_in.data;
        end
    end

    // Error and the three weighted terms
    always_comb begin
        err = ERR_W'(r_s1.setpoint) - ERR_W'(r_s1.measured);
        prod_now   = PROD_W'(r_coef_now)   * PROD_W'(err);
        prod_prev  = PROD_W'(r_coef_prev)  * PROD_W'(r_err_last);
        prod_prev2 = PROD_W'(r_coef_prev2) * PROD_W'(r_err_before_last);
        raw = ACC_W'(r_out_last) + ACC_W'(prod_now)
            + ACC_W'(prod_prev) + ACC_W'(prod_prev2);
    end

    // Clamp; upper limit wins when the limits are crossed
    always_comb begin
        above = raw > ACC_W'(r_out_max);
        below = raw < ACC_W'(r_out_min);
        sat   = above || below;
        n_out.saturated = 1'b0;
        n_out.control_out = '0;
        if (r_s1.cmd == CMD_COMPUTE && r_enable) begin
            n_out.saturated = sat;
            if (above) begin
                n_out.control_out = r_out_max;
            end else if (below) begin
                n_out.control_out = r_out_min;
            end else begin
                n_out.control_out = raw[Q_W-1:0];
            end
        end
        hold_hist = r_windup_guard && sat;
    end

    // History update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_last        <= '0;
            r_err_before_last <= '0;
            r_out_last        <= '0;
        end else if (s1_adv) begin
            if (r_s1.cmd == CMD_CLEAR) begin
                r_err_last        <= '0;
                r_err_before_last <= '0;
                r_out_last        <= '0;
            end else if (r_enable && !hold_hist) begin
                r_err_before_last <= r_err_last;
                r_err_last        <= err;
                r_out_last        <= n_out.control_out;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ptaw_checker.sv
// ---------------------------------------------------------------------------
// ptaw_checker
// Port-level checks on the PID core, bound to every instance of the core.
// ---------------------------------------------------------------------------
`default_nettype none

module ptaw_checker
    import ptaw_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    ptaw_chan_if.sink   i_in,
    ptaw_chan_if.source o_out
);

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid)
        else $error("result dropped while stalled");

    // Stalled result payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.data))
        else $error("result changed while stalled");

    // Empty result side never blocks new requests
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input blocked with result register empty");

    // Reset empties the result side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

endmodule

bind pid_tustin_antiwindup_core ptaw_checker u_ptaw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

`default_nettype wire

>>> tb/sv/pid_tustin_antiwindup_core_test.sv
// ---------------------------------------------------------------------------
// pid_tustin_antiwindup_core_test
// Self-checking bench for the incremental PID core. A clocked driver feeds
// control requests from a queue, a predictor computes the expected Q16.16
// output and saturation flag at each accepted request, and a clocked monitor
// checks each result in order. Register settings change only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_tustin_antiwindup_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptaw_pkg::*;

    // Index that maps to no register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic clk;
    logic rst_n;

    ptaw_chan_if #(.t_payload(t_in_item))  in_ch ();
    ptaw_chan_if #(.t_payload(t_out_item)) out_ch ();
    ptaw_chan_if #(.t_payload(t_cfg_req))  cfg_ch ();

    pid_tustin_antiwindup_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of the register file
    logic signed [Q_W-1:0] reg_coef_now     = '0;
    logic signed [Q_W-1:0] reg_coef_prev    = '0;
    logic signed [Q_W-1:0] reg_coef_prev2   = '0;
    logic signed [Q_W-1:0] reg_out_max      = OUT_MAX_RST;
    logic signed [Q_W-1:0] reg_out_min      = OUT_MIN_RST;
    logic                  reg_windup_guard = 1'b1;
    logic                  reg_enable       = 1'b0;

    // Controller history as the predictor sees it
    logic signed [ERR_W-1:0] hist_err1 = '0;
    logic signed [ERR_W-1:0] hist_err2 = '0;
    logic signed [Q_W-1:0]   hist_out  = '0;

    t_in_item  pending_reqs [$];
    t_out_item ctrl_expected [$];
    int        fail_count = 0;
    int        src_idle_pct = 32;
    int        snk_idle_pct = 60;

    // Expected result of one accepted request; advances the history
    function automatic t_out_item pid_step_predict(t_in_item it);
        logic signed [63:0] err;
        logic signed [63:0] raw;
        t_out_item          r;
        r.control_out = '0;
        r.saturated   = 1'b0;
        if (it.cmd == CMD_CLEAR) begin
            hist_err1 = '0;
            hist_err2 = '0;
            hist_out  = '0;
        end else if (reg_enable) begin
            err = $signed(it.setpoint) - $signed(it.measured);
            raw = hist_out + reg_coef_now * err + reg_coef_prev * hist_err1
                + reg_coef_prev2 * hist_err2;
            // upper limit wins when the limits are crossed
            if (raw > reg_out_max) begin
                r.control_out = reg_out_max;
                r.saturated   = 1'b1;
            end else if (raw < reg_out_min) begin
                r.control_out = reg_out_min;
                r.saturated   = 1'b1;
            end else begin
                r.control_out = raw[Q_W-1:0];
            end
            if (!(reg_windup_guard && r.saturated)) begin
                hist_err2 = hist_err1;
                hist_err1 = err[ERR_W-1:0];
                hist_out  = r.control_out;
            end
        end
        return r;
    endfunction

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                ctrl_expected.push_back(pid_step_predict(in_ch.data));
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_reqs.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk) begin : result_mon
        t_out_item want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (ctrl_expected.size() == 0) begin
                    $display("%0t: unexpected result, control_out %0d saturated %0b",
                             $time, out_ch.data.control_out, out_ch.data.saturated);
                    fail_count++;
                end else begin
                    want = ctrl_expected.pop_front();
                    if (out_ch.data.control_out !== want.control_out) begin
                        $display("%0t: control_out mismatch, expected %0d, actual %0d",
                                 $time, want.control_out, out_ch.data.control_out);
                        fail_count++;
                    end
                    if (out_ch.data.saturated !== want.saturated) begin
                        $display("%0t: saturated mismatch, expected %0b, actual %0b",
                                 $time, want.saturated, out_ch.data.saturated);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    // Register writes seen by the shadow copy
    always @(posedge clk) begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.data.index)
                CFG_COEF_NOW:     reg_coef_now     <= cfg_ch.data.wdata;
                CFG_COEF_PREV:    reg_coef_prev    <= cfg_ch.data.wdata;
                CFG_COEF_PREV2:   reg_coef_prev2   <= cfg_ch.data.wdata;
                CFG_OUT_MAX:      reg_out_max      <= cfg_ch.data.wdata;
                CFG_OUT_MIN:      reg_out_min      <= cfg_ch.data.wdata;
                CFG_WINDUP_GUARD: reg_windup_guard <= cfg_ch.data.wdata[0];
                CFG_ENABLE:       reg_enable       <= cfg_ch.data.wdata[0];
                default: ;
            endcase
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.wdata <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [Q_W-1:0] c0, input logic [Q_W-1:0] c1,
                                input logic [Q_W-1:0] c2, input logic [Q_W-1:0] hi,
                                input logic [Q_W-1:0] lo, input logic guard,
                                input logic en);
        reg_write(CFG_COEF_NOW, c0);
        reg_write(CFG_COEF_PREV, c1);
        reg_write(CFG_COEF_PREV2, c2);
        reg_write(CFG_OUT_MAX, hi);
        reg_write(CFG_OUT_MIN, lo);
        reg_write(CFG_WINDUP_GUARD, {31'd0, guard});
        reg_write(CFG_ENABLE, {31'd0, en});
    endtask

    task automatic push_req(input logic cmd, input int sp, input int pv);
        t_in_item it;
        it.cmd      = cmd;
        it.setpoint = 16'(sp);
        it.measured = 16'(pv);
        pending_reqs.push_back(it);
    endtask

    // Wait until every request went out and every result came back
    task automatic wait_idle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_ch.valid || ctrl_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random register setting: small or full-range weights, varied limits
    task automatic program_random();
        int          a;
        int          b;
        int          t;
        int          sel;
        logic [31:0] c [3];
        logic        en;
        sel = $urandom_range(2, 0);
        for (int k = 0; k < 3; k++)
            c[k] = (sel == 0) ? $urandom : 32'($urandom_range(1 << 18, 0) - (1 << 17));
        sel = $urandom_range(9, 0);
        if (sel <= 3) begin
            a = $urandom;
            b = $urandom;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            // occasionally leave the limits crossed
            if (sel == 0) begin
                t = a;
                a = b;
                b = t;
            end
        end else begin
            b = $urandom_range(1 << 28, 1 << 16);
            a = -b;
        end
        en = ($urandom_range(9, 0) != 0);
        program_regs(c[0], c[1], c[2], 32'(b), 32'(a), 1'($urandom_range(1, 0)), en);
        if ($urandom_range(3, 0) == 0)
            reg_write(CFG_UNUSED_IDX, $urandom);
    endtask

    task automatic push_random(input int n);
        int sp;
        int pv;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99, 0) < 30) begin
                sp = $urandom_range(65535, 0) - 32768;
                pv = $urandom_range(65535, 0) - 32768;
            end else begin
                sp = $urandom_range(2000, 0) - 1000;
                pv = sp + $urandom_range(200, 0) - 100;
            end
            push_req(($urandom_range(99, 0) < 4) ? CMD_CLEAR : CMD_COMPUTE, sp, pv);
        end
    endtask

    // Stimulus
    initial begin
        int half;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Disabled after reset: zero output, clear still accepted
        push_req(CMD_COMPUTE, 32767, -32768);
        push_req(CMD_COMPUTE, -32768, 32767);
        push_req(CMD_CLEAR, 32767, -1);
        wait_idle();

        // Moderate weights, limits at +/-100
        program_regs(32'sh0001_0000, 32'shFFFF_8000, 32'sh0000_4000,
                     32'(100 << 16), 32'(-(100 << 16)), 1'b1, 1'b1);
        push_req(CMD_COMPUTE, 10, 3);
        push_req(CMD_COMPUTE, 0, 0);
        push_req(CMD_COMPUTE, -5, 20);
        push_req(CMD_COMPUTE, 32767, -32768);
        push_req(CMD_COMPUTE, -32768, 32767);
        push_req(CMD_COMPUTE, -1, -1);
        push_req(CMD_CLEAR, -32768, 32767);
        push_req(CMD_COMPUTE, 1, 0);
        wait_idle();

        // Guard off: history follows the clamped output
        reg_write(CFG_WINDUP_GUARD, 32'd0);
        push_req(CMD_COMPUTE, 32767, -32768);
        push_req(CMD_COMPUTE, 32767, -32768);
        push_req(CMD_COMPUTE, 0, 0);
        wait_idle();

        // Crossed limits: upper bound is tested first
        reg_write(CFG_OUT_MAX, 32'(-(5 << 16)));
        reg_write(CFG_OUT_MIN, 32'(5 << 16));
        push_req(CMD_CLEAR, 0, 0);
        push_req(CMD_COMPUTE, 20, 0);
        push_req(CMD_COMPUTE, -20, 0);
        push_req(CMD_COMPUTE, 0, 0);
        wait_idle();

        // Full-scale weights and limits
        program_regs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     OUT_MAX_RST, OUT_MIN_RST, 1'b0, 1'b1);
        reg_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        push_req(CMD_COMPUTE, 32767, -32768);
        push_req(CMD_COMPUTE, -32768, 32767);
        push_req(CMD_COMPUTE, 32767, -32768);
        wait_idle();

        // Random settings across the three stall profiles
        for (int s = 0; s < 6; s++) begin
            if (s == 2) begin
                src_idle_pct = 60;
                snk_idle_pct = 32;
            end else if (s == 4) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            program_random();
            push_req(CMD_CLEAR, 0, 0);
            half = $urandom_range(70, 40);
            push_random(half);
            // hold the sender until the pipe drains, then continue
            wait_idle();
            push_random(115 - half);
            wait_idle();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> pid_tustin_antiwindup_core.f
hdl/ptaw_pkg.sv
hdl/ptaw_chan_if.sv
hdl/pid_tustin_antiwindup_core.sv
hdl/ptaw_checker.sv
tb/sv/pid_tustin_antiwindup_core_test.sv
